>>> rtl/core/tpzr_pkg.sv
// Shared constants, tables and types for the torus point z-buffer renderer.
// Holds the sine and palette tables and the structs, two of which cross module bounds.
// Depends on nothing.
`default_nettype none
package tpzr_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(PIX_COUNT);

  // fixed field widths
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int DEPTH_W = 17;
  localparam int COLOR_W = 32;
  localparam int VAL_W   = 28;   // working width of the geometry registers
  localparam int MB_W    = 19;   // second multiplier operand
  localparam int PROD_W  = VAL_W + MB_W;
  localparam int DIV_W   = 20;   // divisor width
  localparam int QUO_W   = 25;   // quotient width of 2^24 / d

  // fixed-point constants
  localparam int ONE_FX     = 65536;
  localparam int CAM_DIST   = 5 * ONE_FX;
  localparam int NEAR_LIMIT = ONE_FX / 2;
  localparam int LIGHT_C    = 37814;
  localparam int PROJ_SCALE = 130;
  localparam int DEPTH_MAX  = 131071;
  localparam logic [COLOR_W-1:0] BG_COLOR = 32'hFF080C14;

  // item ops
  localparam logic [1:0] OP_PLOT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_ROT_A   = 2'd0;
  localparam logic [1:0] CFG_ROT_B   = 2'd1;
  localparam logic [1:0] CFG_PALETTE = 2'd2;

  // first quarter of a sine turn, 16.16
  localparam logic [16:0] QSINE [65] = '{
    17'd0,     17'd1608,  17'd3216,  17'd4821,  17'd6424,  17'd8022,  17'd9616,  17'd11204,
    17'd12785, 17'd14359, 17'd15924, 17'd17479, 17'd19024, 17'd20557, 17'd22078, 17'd23586,
    17'd25080, 17'd26558, 17'd28020, 17'd29466, 17'd30893, 17'd32303, 17'd33692, 17'd35062,
    17'd36410, 17'd37736, 17'd39040, 17'd40320, 17'd41576, 17'd42806, 17'd44011, 17'd45190,
    17'd46341, 17'd47464, 17'd48559, 17'd49624, 17'd50660, 17'd51665, 17'd52639, 17'd53581,
    17'd54491, 17'd55368, 17'd56212, 17'd57022, 17'd57798, 17'd58538, 17'd59244, 17'd59914,
    17'd60547, 17'd61145, 17'd61705, 17'd62228, 17'd62714, 17'd63162, 17'd63572, 17'd63944,
    17'd64277, 17'd64571, 17'd64827, 17'd65043, 17'd65220, 17'd65358, 17'd65457, 17'd65516,
    17'd65536
  };

  // shade palettes: golden, neon, magma, emerald
  localparam logic [31:0] PALETTE [4][16] = '{
    '{32'hFF1A0A02, 32'hFF2E1304, 32'hFF451D08, 32'hFF5C280D,
      32'hFF733312, 32'hFF8A3E17, 32'hFFA1491D, 32'hFFB85523,
      32'hFFCF622B, 32'hFFE07336, 32'hFFED8547, 32'hFFF5995E,
      32'hFFFCAE77, 32'hFFFCC595, 32'hFFFDDAB5, 32'hFFFFF0D6},
    '{32'hFF0D021A, 32'hFF1B0533, 32'hFF2E0A4F, 32'hFF46106E,
      32'hFF63188F, 32'hFF8321B0, 32'hFFA42BD0, 32'hFFC537ED,
      32'hFFDE45F7, 32'hFFE65DF7, 32'hFFC97AF7, 32'hFF96A5FA,
      32'hFF62D2FC, 32'hFF4AE2FC, 32'hFF7BF0FD, 32'hFFE0FFFF},
    '{32'hFF150402, 32'hFF2A0603, 32'hFF450904, 32'hFF660D06,
      32'hFF8A1207, 32'hFFB01908, 32'hFFD42509, 32'hFFF03B0D,
      32'hFFF75815, 32'hFFFA771F, 32'hFFFC992D, 32'hFFFDBC42,
      32'hFFFED860, 32'hFFFEEC87, 32'hFFFFF8B8, 32'hFFFFFFF0},
    '{32'hFF021204, 32'hFF042108, 32'hFF07360E, 32'hFF0B4F15,
      32'hFF106B1E, 32'hFF168A28, 32'hFF1EAA34, 32'hFF27CB41,
      32'hFF36E852, 32'hFF57F06E, 32'hFF7CF48E, 32'hFFA0F7B0,
      32'hFFC3FBD1, 32'hFFDFFDE8, 32'hFFF2FFF6, 32'hFFFFFFFF}
  };

  // sine of an 8-bit angle, 256 steps per turn, signed 16.16
  function automatic logic signed [17:0] sine8(input logic [7:0] ang);
    logic [6:0]  q;
    logic [6:0]  idx;
    logic [17:0] mag;
    q   = ang[6:0];
    idx = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
    mag = {1'b0, QSINE[idx]};
    sine8 = ang[7] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [17:0] cosine8(input logic [7:0] ang);
    cosine8 = sine8(ang + 8'd64);
  endfunction

  // pixel store access
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] color;
  } pix_req_t;

  // geometry result for one plot item
  typedef struct packed {
    logic               hit;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  base;
  } geo_res_t;

  // one multiply step of the geometry sequencer
  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [MB_W-1:0]  b;
    logic [4:0]              dst;
    logic                    acc;
    logic                    neg;
    logic                    wide;
  } mul_op_t;

endpackage
`default_nettype wire

>>> rtl/core/torus_point_zbuffer_renderer.sv
// Torus point renderer with a depth-tested frame buffer of 320x200 pixels.
// Flow: a clear item writes in ST_CLR; a read requests in ST_RD_RQ and takes
// its data in ST_RD_DAT. A plot item runs up to 29 products on one shared
// multiplier, a 25-step bit-serial reciprocal divider unless the point is too
// near, and a 2x2 splat if it lands in the window (read then conditional write
// per pixel on the single-port pixel store). One item is in work at a time; the
// result register lets the next item be taken while a result waits. The pixel
// store is not cleared at reset: pixels read back before a clear or plot are
// undefined. Uses tpzr_pkg, tpzr_geom and tpzr_pixmem.
`default_nettype none
module torus_point_zbuffer_renderer
  import tpzr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // ring_angle[7:0], tube_angle[15:8], pixel_addr[31:16]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // pixel_color[31:0], screen_x[40:32], screen_y[48:41]
  output logic             m_tuser    // plotted[0]
);

  // control states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GEOM   = 3'd1;
  localparam logic [2:0] ST_SPL_RD = 3'd2;
  localparam logic [2:0] ST_SPL_WR = 3'd3;
  localparam logic [2:0] ST_CLR    = 3'd4;
  localparam logic [2:0] ST_RD_RQ  = 3'd5;
  localparam logic [2:0] ST_RD_DAT = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]         state;
  logic [7:0]         rot_a;
  logic [7:0]         rot_b;
  logic [1:0]         pal_sel;
  logic [ADDR_W-1:0]  addr;
  logic               addr_ok;
  logic [1:0]         pix_cnt;
  logic [COLOR_W-1:0] res_color;
  logic               res_plot;
  logic [X_W-1:0]     res_x;
  logic [Y_W-1:0]     res_y;
  logic [COLOR_W-1:0] out_color;
  logic               out_plot;
  logic [X_W-1:0]     out_x;
  logic [Y_W-1:0]     out_y;

  logic               accept;
  logic               geo_done;
  geo_res_t           geo;
  pix_req_t           mem_req;
  logic [DEPTH_W-1:0] rd_depth;
  logic [COLOR_W-1:0] rd_color;
  logic [ADDR_W-1:0]  spl_addr;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_a   <= '0;
      rot_b   <= '0;
      pal_sel <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROT_A:   rot_a   <= cfg_data;
        CFG_ROT_B:   rot_b   <= cfg_data;
        CFG_PALETTE: pal_sel <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  tpzr_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .start      (accept && s_tuser == OP_PLOT),
    .ring_angle (s_tdata[7:0]),
    .tube_angle (s_tdata[15:8]),
    .rot_a      (rot_a),
    .rot_b      (rot_b),
    .pal_sel    (pal_sel),
    .done       (geo_done),
    .res        (geo)
  );

  // splat pixel: base, right, below, below right
  assign spl_addr = geo.base + (pix_cnt[1] ? ADDR_W'(SCREEN_WIDTH) : '0) + ADDR_W'(pix_cnt[0]);

  // pixel store requests
  always_comb begin
    mem_req = '0;
    case (state)
      ST_SPL_RD: begin
        mem_req.rd   = 1'b1;
        mem_req.addr = spl_addr;
      end
      ST_SPL_WR: begin
        mem_req.wr    = geo.depth > rd_depth;
        mem_req.addr  = spl_addr;
        mem_req.depth = geo.depth;
        mem_req.color = geo.color;
      end
      ST_CLR: begin
        mem_req.wr    = addr_ok;
        mem_req.addr  = addr;
        mem_req.depth = '0;
        mem_req.color = BG_COLOR;
      end
      ST_RD_RQ: begin
        mem_req.rd   = addr_ok;
        mem_req.addr = addr;
      end
      default: mem_req = '0;
    endcase
  end

  tpzr_pixmem u_pixmem (
    .clk      (clk),
    .req      (mem_req),
    .rd_depth (rd_depth),
    .rd_color (rd_color)
  );

  // item control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pix_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result register load or drain
      if (state == ST_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              OP_PLOT:  state <= ST_GEOM;
              OP_CLEAR: state <= ST_CLR;
              OP_READ:  state <= ST_RD_RQ;
              default:  state <= ST_FIN;
            endcase
          end
        end
        ST_GEOM: begin
          if (geo_done) begin
            pix_cnt <= '0;
            state   <= geo.hit ? ST_SPL_RD : ST_FIN;
          end
        end
        ST_SPL_RD: state <= ST_SPL_WR;
        ST_SPL_WR: begin
          pix_cnt <= pix_cnt + 2'd1;
          state   <= (pix_cnt == 2'd3) ? ST_FIN : ST_SPL_RD;
        end
        ST_CLR:    state <= ST_FIN;
        ST_RD_RQ:  state <= ST_RD_DAT;
        ST_RD_DAT: state <= ST_FIN;
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      addr      <= s_tdata[16 +: ADDR_W];
      addr_ok   <= s_tdata[31:16] < 16'(PIX_COUNT);
      res_color <= '0;
      res_plot  <= 1'b0;
      res_x     <= '0;
      res_y     <= '0;
    end
    if (state == ST_GEOM && geo_done && geo.hit) begin
      res_plot <= 1'b1;
      res_x    <= geo.x;
      res_y    <= geo.y;
    end
    if (state == ST_RD_DAT && addr_ok) begin
      res_color <= rd_color;
    end
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      out_color <= res_color;
      out_plot  <= res_plot;
      out_x     <= res_x;
      out_y     <= res_y;
    end
  end

  assign m_tdata = {7'b0, out_y, out_x, out_color};
  assign m_tuser = out_plot;

`ifndef SYNTH
  a_geo_done_in_geom: assert property (@(posedge clk) disable iff (rst)
    geo_done |-> state == ST_GEOM)
    else $error("geometry finished outside of a plot");

  a_mem_wr_state: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr |-> (state == ST_SPL_WR || state == ST_CLR))
    else $error("pixel write outside splat or clear");

  a_mem_addr_range: assert property (@(posedge clk) disable iff (rst)
    (mem_req.rd || mem_req.wr) |-> mem_req.addr < ADDR_W'(PIX_COUNT))
    else $error("pixel access beyond the frame");

  a_plot_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && res_plot) |->
      (res_x >= 9'd1 && res_x < X_W'(SCREEN_WIDTH - 2) &&
       res_y >= 8'd16 && res_y < Y_W'(SCREEN_HEIGHT - 18)))
    else $error("plotted point outside the visible window");

  a_unplotted_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !res_plot) |-> (res_x == '0 && res_y == '0))
    else $error("coordinates set on an unplotted item");
`endif

endmodule
`default_nettype wire

>>> rtl/core/tpzr_pixmem.sv
// Pixel store: depth and color memories sharing one address port.
// Read data is registered. Uses tpzr_pkg.
`default_nettype none
module tpzr_pixmem
  import tpzr_pkg::*;
(
  input  wire logic               clk,
  input  wire pix_req_t           req,
  output logic [DEPTH_W-1:0]      rd_depth,
  output logic [COLOR_W-1:0]      rd_color
);

  logic [DEPTH_W-1:0] depth_mem [PIX_COUNT];
  logic [COLOR_W-1:0] color_mem [PIX_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr) begin
      depth_mem[req.addr] <= req.depth;
      color_mem[req.addr] <= req.color;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_depth <= depth_mem[req.addr];
      rd_color <= color_mem[req.addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tpzr_div.sv
// Restoring divider for the reciprocal depth 2^24 / d, one bit per cycle.
// Uses tpzr_pkg for widths.
`default_nettype none
module tpzr_div
  import tpzr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  logic               busy;
  logic [4:0]         cnt;
  logic [DIV_W-1:0]   dvs;
  logic [DIV_W:0]     rem;
  logic [QUO_W-1:0]   num;
  logic [DIV_W+1:0]   shifted;
  logic [DIV_W+1:0]   diff;

  // one trial subtraction per cycle
  assign shifted = {rem, num[QUO_W-1]};
  assign diff    = shifted - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      num      <= QUO_W'(1) << (QUO_W - 1);
      quotient <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (!diff[DIV_W+1]) begin
        rem      <= diff[DIV_W:0];
        quotient <= {quotient[QUO_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[DIV_W:0];
        quotient <= {quotient[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tpzr_geom.sv
// Geometry engine: rotation, lighting and projection of one torus sample.
// One shared multiplier stepped by a sequencer, plus tpzr_div. Uses tpzr_pkg.
`default_nettype none
module tpzr_geom
  import tpzr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [7:0] ring_angle,
  input  wire logic [7:0] tube_angle,
  input  wire logic [7:0] rot_a,
  input  wire logic [7:0] rot_b,
  input  wire logic [1:0] pal_sel,
  output logic            done,
  output geo_res_t        res
);

  // sequencer states
  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_MUL  = 3'd1;
  localparam logic [2:0] G_WB   = 3'd2;
  localparam logic [2:0] G_ZC   = 3'd3;
  localparam logic [2:0] G_DIVW = 3'd4;
  localparam logic [2:0] G_PROJ = 3'd5;

  // destination registers
  localparam logic [4:0] D_M01   = 5'd0;
  localparam logic [4:0] D_M02   = 5'd1;
  localparam logic [4:0] D_M11   = 5'd2;
  localparam logic [4:0] D_M12   = 5'd3;
  localparam logic [4:0] D_X0    = 5'd4;
  localparam logic [4:0] D_Y0    = 5'd5;
  localparam logic [4:0] D_NX0   = 5'd6;
  localparam logic [4:0] D_NY0   = 5'd7;
  localparam logic [4:0] D_X2    = 5'd8;
  localparam logic [4:0] D_Y2    = 5'd9;
  localparam logic [4:0] D_Z2    = 5'd10;
  localparam logic [4:0] D_NX2   = 5'd11;
  localparam logic [4:0] D_NY2   = 5'd12;
  localparam logic [4:0] D_NZ2   = 5'd13;
  localparam logic [4:0] D_LIGHT = 5'd14;
  localparam logic [4:0] D_OFFX  = 5'd15;
  localparam logic [4:0] D_OFFY  = 5'd16;

  localparam logic [4:0] STEP_LIGHT_END = 5'd26;
  localparam logic [4:0] STEP_PROJ_X    = 5'd27;
  localparam logic [4:0] STEP_LAST      = 5'd28;

  logic [2:0] state;
  logic [4:0] step;

  logic signed [17:0] sa, ca, sb, cb, sp, cp, st, ct;
  logic [1:0]         pal;
  logic signed [VAL_W-1:0] m01, m02, m11, m12;
  logic signed [VAL_W-1:0] x0, y0, nx0, ny0;
  logic signed [VAL_W-1:0] x2, y2, z2, nx2, ny2, nz2, light;
  logic signed [VAL_W-1:0] offx, offy, tx, ty;
  logic [17:0]             recip;
  logic signed [PROD_W-1:0] prod;

  logic signed [VAL_W-1:0] cx;
  logic signed [VAL_W-1:0] zc;
  mul_op_t                 mop;
  logic signed [VAL_W-1:0] fx, val, dst_old, wval;

  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_q;

  function automatic logic signed [VAL_W-1:0] ext18(input logic signed [17:0] v);
    ext18 = VAL_W'(v);
  endfunction

  function automatic logic signed [MB_W-1:0] narrow(input logic signed [VAL_W-1:0] v);
    narrow = v[MB_W-1:0];
  endfunction

  assign cx = VAL_W'(2 * ONE_FX) + ext18(ct);
  assign zc = z2 + VAL_W'(CAM_DIST);

  // multiply step table
  always_comb begin
    mop = '0;
    case (step)
      5'd0:  mop = '{ext18(sb), MB_W'(ca), D_M01, 1'b0, 1'b1, 1'b0};
      5'd1:  mop = '{ext18(sb), MB_W'(sa), D_M02, 1'b0, 1'b0, 1'b0};
      5'd2:  mop = '{ext18(cb), MB_W'(ca), D_M11, 1'b0, 1'b0, 1'b0};
      5'd3:  mop = '{ext18(cb), MB_W'(sa), D_M12, 1'b0, 1'b1, 1'b0};
      5'd4:  mop = '{cx, MB_W'(cp), D_X0, 1'b0, 1'b0, 1'b0};
      5'd5:  mop = '{cx, MB_W'(sp), D_Y0, 1'b0, 1'b0, 1'b0};
      5'd6:  mop = '{ext18(ct), MB_W'(cp), D_NX0, 1'b0, 1'b0, 1'b0};
      5'd7:  mop = '{ext18(ct), MB_W'(sp), D_NY0, 1'b0, 1'b0, 1'b0};
      5'd8:  mop = '{x0, MB_W'(cb), D_X2, 1'b0, 1'b0, 1'b0};
      5'd9:  mop = '{y0, narrow(m01), D_X2, 1'b1, 1'b0, 1'b0};
      5'd10: mop = '{ext18(st), narrow(m02), D_X2, 1'b1, 1'b0, 1'b0};
      5'd11: mop = '{x0, MB_W'(sb), D_Y2, 1'b0, 1'b0, 1'b0};
      5'd12: mop = '{y0, narrow(m11), D_Y2, 1'b1, 1'b0, 1'b0};
      5'd13: mop = '{ext18(st), narrow(m12), D_Y2, 1'b1, 1'b0, 1'b0};
      5'd14: mop = '{y0, MB_W'(sa), D_Z2, 1'b0, 1'b0, 1'b0};
      5'd15: mop = '{ext18(st), MB_W'(ca), D_Z2, 1'b1, 1'b0, 1'b0};
      5'd16: mop = '{nx0, MB_W'(cb), D_NX2, 1'b0, 1'b0, 1'b0};
      5'd17: mop = '{ny0, narrow(m01), D_NX2, 1'b1, 1'b0, 1'b0};
      5'd18: mop = '{ext18(st), narrow(m02), D_NX2, 1'b1, 1'b0, 1'b0};
      5'd19: mop = '{nx0, MB_W'(sb), D_NY2, 1'b0, 1'b0, 1'b0};
      5'd20: mop = '{ny0, narrow(m11), D_NY2, 1'b1, 1'b0, 1'b0};
      5'd21: mop = '{ext18(st), narrow(m12), D_NY2, 1'b1, 1'b0, 1'b0};
      5'd22: mop = '{ny0, MB_W'(sa), D_NZ2, 1'b0, 1'b0, 1'b0};
      5'd23: mop = '{ext18(st), MB_W'(ca), D_NZ2, 1'b1, 1'b0, 1'b0};
      5'd24: mop = '{nx2, MB_W'(LIGHT_C), D_LIGHT, 1'b0, 1'b0, 1'b0};
      5'd25: mop = '{ny2, MB_W'(LIGHT_C), D_LIGHT, 1'b1, 1'b0, 1'b0};
      5'd26: mop = '{nz2, -MB_W'(LIGHT_C), D_LIGHT, 1'b1, 1'b0, 1'b0};
      5'd27: mop = '{tx, MB_W'({1'b0, recip}), D_OFFX, 1'b0, 1'b0, 1'b1};
      5'd28: mop = '{ty, MB_W'({1'b0, recip}), D_OFFY, 1'b0, 1'b0, 1'b1};
      default: mop = '0;
    endcase
  end

  // current value of the destination, for accumulation
  always_comb begin
    case (mop.dst)
      D_X2:    dst_old = x2;
      D_Y2:    dst_old = y2;
      D_Z2:    dst_old = z2;
      D_NX2:   dst_old = nx2;
      D_NY2:   dst_old = ny2;
      D_NZ2:   dst_old = nz2;
      D_LIGHT: dst_old = light;
      default: dst_old = '0;
    endcase
  end

  // floor shift of the product, then sign and accumulate
  assign fx   = mop.wide ? VAL_W'($signed(prod[PROD_W-1:32]))
                         : prod[VAL_W+15:16];
  assign val  = mop.neg ? -fx : fx;
  assign wval = mop.acc ? dst_old + val : val;

  // projection and shading from the final offsets
  logic [16:0]             xp;
  logic [16:0]             yp;
  logic                    in_win;
  logic signed [VAL_W-1:0] lsum;
  logic signed [VAL_W-1:0] lvl;
  logic [3:0]              lum;
  logic [DEPTH_W-1:0]      depth;

  assign xp = 17'(SCREEN_WIDTH / 2) + offx[16:0];
  assign yp = 17'(SCREEN_HEIGHT / 2) - offy[16:0];
  assign in_win = (xp >= 17'd1) && (xp < 17'(SCREEN_WIDTH - 2)) &&
                  (yp >= 17'd16) && (yp < 17'(SCREEN_HEIGHT - 18));
  assign lsum = light + VAL_W'(ONE_FX);
  assign lvl  = lsum >>> 13;
  assign lum  = (lvl < 0) ? 4'd0 : ((lvl > 15) ? 4'd15 : lvl[3:0]);
  assign depth = (recip > 18'(DEPTH_MAX)) ? DEPTH_W'(DEPTH_MAX) : recip[DEPTH_W-1:0];

  assign div_start = (state == G_ZC) && (zc > VAL_W'(NEAR_LIMIT));

  tpzr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (zc[DIV_W+7:8]),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        G_IDLE: begin
          if (start) begin
            state <= G_MUL;
            step  <= '0;
          end
        end
        G_MUL: state <= G_WB;
        G_WB: begin
          step <= step + 5'd1;
          if (step == STEP_LIGHT_END) begin
            state <= G_ZC;
          end else if (step == STEP_LAST) begin
            state <= G_PROJ;
          end else begin
            state <= G_MUL;
          end
        end
        G_ZC: begin
          if (div_start) begin
            state <= G_DIVW;
          end else begin
            state <= G_IDLE;
            done  <= 1'b1;
          end
        end
        G_DIVW: begin
          if (div_done) begin
            state <= G_MUL;
            step  <= STEP_PROJ_X;
          end
        end
        G_PROJ: begin
          state <= G_IDLE;
          done  <= 1'b1;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == G_IDLE && start) begin
      sa  <= sine8(rot_a);
      ca  <= cosine8(rot_a);
      sb  <= sine8(rot_b);
      cb  <= cosine8(rot_b);
      sp  <= sine8(ring_angle);
      cp  <= cosine8(ring_angle);
      st  <= sine8(tube_angle);
      ct  <= cosine8(tube_angle);
      pal <= pal_sel;
    end
    if (state == G_MUL) begin
      prod <= PROD_W'(mop.a) * PROD_W'(mop.b);
    end
    if (state == G_WB) begin
      case (mop.dst)
        D_M01:   m01   <= wval;
        D_M02:   m02   <= wval;
        D_M11:   m11   <= wval;
        D_M12:   m12   <= wval;
        D_X0:    x0    <= wval;
        D_Y0:    y0    <= wval;
        D_NX0:   nx0   <= wval;
        D_NY0:   ny0   <= wval;
        D_X2:    x2    <= wval;
        D_Y2:    y2    <= wval;
        D_Z2:    z2    <= wval;
        D_NX2:   nx2   <= wval;
        D_NY2:   ny2   <= wval;
        D_NZ2:   nz2   <= wval;
        D_LIGHT: light <= wval;
        D_OFFX:  offx  <= wval;
        D_OFFY:  offy  <= wval;
        default: ;
      endcase
    end
    // scale by the projection factor ahead of the reciprocal
    if (state == G_ZC) begin
      tx <= (x2 <<< 7) + (x2 <<< 1);
      ty <= (y2 <<< 7) + (y2 <<< 1);
    end
    if (state == G_DIVW && div_done) begin
      recip <= div_q[17:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == G_ZC && !div_start) begin
      res.hit <= 1'b0;
    end else if (state == G_PROJ) begin
      res.hit   <= in_win;
      res.x     <= xp[X_W-1:0];
      res.y     <= yp[Y_W-1:0];
      res.depth <= depth;
      res.color <= PALETTE[pal][lum];
      res.base  <= ADDR_W'(yp[Y_W-1:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(xp[X_W-1:0]);
    end
  end

endmodule
`default_nettype wire

>>> verif/tb_torus_point_zbuffer_renderer.sv
// Testbench for the torus point z-buffer renderer: random and directed plot,
// clear, read and unused-op items checked against a built-in predictor of geometry and
// pixel store. Depends on tpzr_pkg and the renderer RTL.
`timescale 1ns / 100ps
module tb_torus_point_zbuffer_renderer;
  import tpzr_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ring;
    logic [7:0]  tube;
    logic [15:0] addr;
  } render_item_t;

  typedef struct packed {
    logic [31:0] color;
    logic        plotted;
    logic [8:0]  sx;
    logic [7:0]  sy;
  } render_res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_index = CFG_ROT_A;
  logic [7:0] cfg_data = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [31:0] s_tdata = 0;
  logic [1:0] s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [55:0] m_tdata;
  logic m_tuser;
  logic s_tready_q = 0;

  torus_point_zbuffer_renderer dut (.*);

  initial forever #4 clk = ~clk;

  // predictor state; written marks pixels that queued clear items will have written
  logic [16:0] depth_mem [PIX_COUNT];
  logic [31:0] color_mem [PIX_COUNT];
  bit          written   [PIX_COUNT];
  logic [7:0]  rot_a, rot_b;
  logic [1:0]  pal_sel;

  render_item_t pending_items[$];
  render_res_t  expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int pushed = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic longint floor16(input longint v);
    return v >>> 16;
  endfunction

  function automatic longint fx(input longint a, input longint b);
    return floor16(a * b);
  endfunction

  function automatic longint sin_fx(input logic [7:0] ang);
    logic [6:0] q;
    longint v;
    q = ang[6:0];
    v = (q <= 64) ? QSINE[q] : QSINE[128 - q];
    return ang[7] ? -v : v;
  endfunction

  function automatic longint cos_fx(input logic [7:0] ang);
    return sin_fx(ang + 8'd64);
  endfunction

  function automatic void splat_pixel(input int idx, input logic [16:0] d, input logic [31:0] c);
    if (idx < PIX_COUNT && d > depth_mem[idx]) begin
      depth_mem[idx] = d;
      color_mem[idx] = c;
    end
  endfunction

  // geometry of a plot item, updating the pixel store when commit is set
  function automatic render_res_t plot_torus_point(input logic [7:0] ring, input logic [7:0] tube,
                                                   input bit commit);
    render_res_t r;
    longint sa, ca, sb, cb, m01, m02, m11, m12, sp, cp, st, ct, cx;
    longint x0, y0, z0, nx0, ny0, nz0, x2, y2, z2, nx2, ny2, nz2, light, zc, recip, xp, yp, lum;
    int base;
    r = '0;
    sa = sin_fx(rot_a); ca = cos_fx(rot_a); sb = sin_fx(rot_b); cb = cos_fx(rot_b);
    m01 = -fx(sb, ca); m02 = fx(sb, sa); m11 = fx(cb, ca); m12 = -fx(cb, sa);
    sp = sin_fx(ring); cp = cos_fx(ring); st = sin_fx(tube); ct = cos_fx(tube);
    cx = 2 * ONE_FX + fx(ONE_FX, ct);
    x0 = fx(cx, cp); y0 = fx(cx, sp); z0 = fx(ONE_FX, st);
    nx0 = fx(ct, cp); ny0 = fx(ct, sp); nz0 = st;
    x2 = fx(cb, x0) + fx(m01, y0) + fx(m02, z0);
    y2 = fx(sb, x0) + fx(m11, y0) + fx(m12, z0);
    z2 = fx(sa, y0) + fx(ca, z0);
    nx2 = fx(cb, nx0) + fx(m01, ny0) + fx(m02, nz0);
    ny2 = fx(sb, nx0) + fx(m11, ny0) + fx(m12, nz0);
    nz2 = fx(sa, ny0) + fx(ca, nz0);
    light = fx(nx2, LIGHT_C) + fx(ny2, LIGHT_C) + fx(nz2, -LIGHT_C);
    zc = z2 + CAM_DIST;
    if (zc <= NEAR_LIMIT) return r;
    recip = 16777216 / (zc >>> 8);
    xp = SCREEN_WIDTH / 2 + floor16(fx(fx(x2, PROJ_SCALE * ONE_FX), recip));
    yp = SCREEN_HEIGHT / 2 - floor16(fx(fx(y2, PROJ_SCALE * ONE_FX), recip));
    if (!(xp >= 1 && xp < SCREEN_WIDTH - 2 && yp >= 16 && yp < SCREEN_HEIGHT - 18)) return r;
    lum = floor16(fx(light + ONE_FX, 8 * ONE_FX));
    if (lum < 0) lum = 0;
    if (lum > 15) lum = 15;
    if (recip > DEPTH_MAX) recip = DEPTH_MAX;
    if (commit) begin
      base = 32'(yp * SCREEN_WIDTH + xp);
      splat_pixel(base, 17'(recip), PALETTE[pal_sel][lum]);
      splat_pixel(base + 1, 17'(recip), PALETTE[pal_sel][lum]);
      splat_pixel(base + SCREEN_WIDTH, 17'(recip), PALETTE[pal_sel][lum]);
      splat_pixel(base + SCREEN_WIDTH + 1, 17'(recip), PALETTE[pal_sel][lum]);
    end
    r.plotted = 1;
    r.sx = xp[8:0];
    r.sy = yp[7:0];
    return r;
  endfunction

  function automatic render_res_t predict_render(input render_item_t it);
    render_res_t r;
    r = '0;
    case (it.op)
      OP_PLOT: r = plot_torus_point(it.ring, it.tube, 1);
      OP_CLEAR: if (it.addr < PIX_COUNT) begin
        color_mem[it.addr] = BG_COLOR;
        depth_mem[it.addr] = 0;
      end
      OP_READ: if (it.addr < PIX_COUNT) r.color = color_mem[it.addr];
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          render_item_t it;
          it = pending_items.pop_front();
          s_tdata <= {it.addr, it.tube, it.ring};
          s_tuser <= it.op;
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // acceptance seen at the rising edge
  always @(posedge clk) begin
    s_tready_q <= 0;
    if (!rst && s_tvalid && s_tready) begin
      render_item_t it;
      it.ring = s_tdata[7:0];
      it.tube = s_tdata[15:8];
      it.addr = s_tdata[31:16];
      it.op = s_tuser;
      expected_results.push_back(predict_render(it));
      s_tready_q <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      render_res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.color) report_mismatch("pixel_color", m_tdata[31:0], want.color);
        if (m_tuser !== want.plotted) report_mismatch("plotted", m_tuser, want.plotted);
        if (m_tdata[40:32] !== want.sx) report_mismatch("screen_x", m_tdata[40:32], want.sx);
        if (m_tdata[48:41] !== want.sy) report_mismatch("screen_y", m_tdata[48:41], want.sy);
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    case (idx)
      CFG_ROT_A: rot_a = val;
      CFG_ROT_B: rot_b = val;
      default: pal_sel = val[1:0];
    endcase
  endtask

  task automatic push_item(input logic [1:0] op, input logic [7:0] ring, input logic [7:0] tube,
                           input logic [15:0] addr);
    render_item_t it;
    it.op = op; it.ring = ring; it.tube = tube; it.addr = addr;
    pending_items.push_back(it);
    if (op == OP_CLEAR && addr < PIX_COUNT) written[addr] = 1;
    pushed++;
  endtask

  // a plot only touches pixels already written, so clear fresh ones first
  task automatic push_plot(input logic [7:0] ring, input logic [7:0] tube,
                           input logic [15:0] addr);
    render_res_t probe;
    int base, p;
    probe = plot_torus_point(ring, tube, 0);
    if (probe.plotted) begin
      base = probe.sy * SCREEN_WIDTH + probe.sx;
      for (int k = 0; k < 4; k++) begin
        p = base + (k % 2) + (k / 2) * SCREEN_WIDTH;
        if (!written[p]) push_item(OP_CLEAR, 8'h00, 8'h00, 16'(p));
      end
    end
    push_item(OP_PLOT, ring, tube, addr);
  endtask

  // a read of a pixel never written is kept out of the stimulus
  function automatic logic [15:0] pick_read_addr();
    int a;
    for (int t = 0; t < 50; t++) begin
      a = $urandom_range(PIX_COUNT - 1);
      if (written[a]) return 16'(a);
    end
    return 16'($urandom_range(PIX_COUNT, 16'hFFFF));
  endfunction

  task automatic random_phase(input int n);
    render_res_t probe;
    int r, a, start;
    start = pushed;
    while (pushed - start < n) begin
      r = $urandom_range(99);
      if (r < 55) push_plot($urandom, $urandom, $urandom);
      else if (r < 70) push_item(OP_CLEAR, $urandom, $urandom,
                                 ($urandom_range(9) == 0) ? $urandom : $urandom_range(PIX_COUNT - 1));
      else if (r < 95) begin
        // read near a point plotted with current settings, else a known pixel or an out-of-range address
        probe = plot_torus_point($urandom, $urandom, 0);
        a = probe.sy * SCREEN_WIDTH + probe.sx + $urandom_range(1) + $urandom_range(1) * SCREEN_WIDTH;
        push_item(OP_READ, $urandom, $urandom, (probe.plotted && written[a]) ? a : pick_read_addr());
      end else push_item(2'd3, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    render_res_t probe;
    for (int i = 0; i < PIX_COUNT; i++) begin
      depth_mem[i] = 0; color_mem[i] = 0; written[i] = 0;
    end
    rot_a = 0; rot_b = 0; pal_sel = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: clears, reads, out-of-range, unused op, plot extremes
    push_item(OP_CLEAR, 8'hFF, 8'hFF, 0);
    push_item(OP_READ, 0, 0, 0);
    push_item(OP_CLEAR, 0, 0, PIX_COUNT - 1);
    push_item(OP_READ, 8'hFF, 8'hFF, PIX_COUNT - 1);
    push_item(OP_CLEAR, 0, 0, 16'hFFFF);
    push_item(OP_READ, 0, 0, 16'hFFFF);
    push_item(OP_READ, 0, 0, PIX_COUNT);
    push_item(2'd3, 8'hFF, 8'hFF, 16'hFFFF);
    push_plot(0, 0, 16'hFFFF);
    push_plot(8'hFF, 8'hFF, 0);
    push_plot(64, 128, 0);
    push_plot(128, 64, 0);
    push_plot(192, 192, 0);
    push_plot(0, 0, 0);
    probe = plot_torus_point(64, 128, 0);
    push_item(OP_READ, 0, 0, 16'(probe.sy * SCREEN_WIDTH + probe.sx));
    wait_drained();

    // phases over several register settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ROT_A, (ph == 1) ? 8'hFF : (ph == 0) ? 8'h00 : $urandom);
      write_reg(CFG_ROT_B, (ph == 1) ? 8'hFF : (ph == 0) ? 8'h00 : $urandom);
      write_reg(CFG_PALETTE, ph % 4);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 84; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 84; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      random_phase(70);
      wait_drained();
      random_phase(70);
      wait_drained();
    end

    if (errors == 0) $display("torus_point_zbuffer_renderer test passed");
    else $display("torus_point_zbuffer_renderer test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("torus_point_zbuffer_renderer test failed");
    $finish;
  end
endmodule
